[rtl/core/bidirectional_case_fold_pattern_search_unit_macros.svh]
// ----------------------------------------------------------------------------
// Pattern search assertion macros
// Shared concurrent assertion forms on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_CASE_FOLD_PATTERN_SEARCH_UNIT_MACROS_SVH
`define BIDIRECTIONAL_CASE_FOLD_PATTERN_SEARCH_UNIT_MACROS_SVH

// Check in the same cycle.
`define BCFPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check in the following cycle.
`define BCFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bcfps_pkg.sv]
// ----------------------------------------------------------------------------
// Pattern search package
// Widths, register indexes, character constants, config type and fold helper.
// ----------------------------------------------------------------------------
package bcfps_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned MAX_BUFFER_DEF  = 65536;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_OUT_W     = 17;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PATTERN_WORDS = 4;
  localparam int unsigned PATTERN_BYTES = 32;
  localparam int unsigned PIDX_W        = $clog2(PATTERN_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKWARD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD  = 3'd6;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

  typedef struct packed {
    logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]                         length;
    logic                                     backward;
    logic                                     fold;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

[rtl/core/bcfps_ifs.sv]
// ----------------------------------------------------------------------------
// Pattern search channels
// Valid/ready interfaces for text bytes in and search results out.
// ----------------------------------------------------------------------------
interface bcfps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic [16:0] search_offset;
  logic        last_byte;

  modport source (output valid, text_byte, search_offset, last_byte, input ready);
  modport sink   (input valid, text_byte, search_offset, last_byte, output ready);
endinterface

interface bcfps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [16:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

[rtl/core/bcfps_regs.sv]
// ----------------------------------------------------------------------------
// Pattern search configuration registers
// Pattern words, length, direction and case fold, written by index.
// ----------------------------------------------------------------------------
module bcfps_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bcfps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcfps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bcfps_pkg::cfg_t                     cfg
);
  import bcfps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern  <= '0;
      cfg_r.length   <= LEN_W'(1);
      cfg_r.backward <= 1'b0;
      cfg_r.fold     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_0: cfg_r.pattern[0] <= cfg_data;
        REG_PATTERN_1: cfg_r.pattern[1] <= cfg_data;
        REG_PATTERN_2: cfg_r.pattern[2] <= cfg_data;
        REG_PATTERN_3: cfg_r.pattern[3] <= cfg_data;
        REG_LENGTH:    cfg_r.length     <= cfg_data[LEN_W-1:0];
        REG_BACKWARD:  cfg_r.backward   <= cfg_data[0];
        REG_CASE_FOLD: cfg_r.fold       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/bcfps_cell.sv]
// ----------------------------------------------------------------------------
// Pattern search window cell
// Holds one window byte, passes it on when shifting, compares with its
// pattern byte.
// ----------------------------------------------------------------------------
module bcfps_cell (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic                           fold_en,
  input  logic [bcfps_pkg::BYTE_W-1:0]   byte_in,
  input  logic [bcfps_pkg::BYTE_W-1:0]   pat_byte,
  output logic [bcfps_pkg::BYTE_W-1:0]   byte_out,
  output logic                           eq
);
  import bcfps_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign eq       = (byte_r == fold_byte(pat_byte, fold_en));

endmodule

[rtl/core/bidirectional_case_fold_pattern_search_unit.sv]
// ----------------------------------------------------------------------------
// Bidirectional case-fold pattern search unit
// Takes one text byte per cycle, one transaction each, and gives one result
// transaction after the last_byte one, via the s1 and output registers. The
// rate is set by the row of window cells, which shifts and compares the whole
// window against the pattern at once; input stalls only while a
// finished result waits on the output. Forward mode reports one past the end
// of the first match starting at or after the offset, backward mode reports
// the start of the latest match ending before it. Up to MAX_PATTERN pattern
// bytes, MAX_BUFFER compared bytes per buffer; later bytes are not compared.
// ----------------------------------------------------------------------------
`include "bidirectional_case_fold_pattern_search_unit_macros.svh"

module bidirectional_case_fold_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN = bcfps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_BUFFER  = bcfps_pkg::MAX_BUFFER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bcfps_in_if.sink                          in_ch,
  bcfps_out_if.source                       out_ch,
  input  logic                              cfg_wr_en,
  input  logic [bcfps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcfps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcfps_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BUFFER + 1);
  localparam int unsigned CW    = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;

  cfg_t                               cfg;
  logic [PATTERN_BYTES*BYTE_W-1:0]    pat_flat;
  logic [LEN_W-1:0]                   len_used;

  logic                               in_fire;
  logic                               cmp_en;
  logic                               shift_en;
  logic [BYTE_W-1:0]                  text_folded;

  logic [POS_W-1:0]                   pos_r;
  logic                               s1_valid_r;
  logic                               s1_cmp_r;
  logic                               s1_last_r;
  logic [POS_W-1:0]                   s1_pos_r;
  logic [POS_OUT_W-1:0]               s1_off_r;
  logic                               s1_fire;
  logic                               out_free;

  logic [BYTE_W-1:0]                  win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]             eq;
  logic [MAX_PATTERN-1:0]             used_mask;
  logic                               all_eq;

  logic [CW-1:0]                      end_pos;
  logic [CW-1:0]                      start_pos;
  logic [CW-1:0]                      len_cw;
  logic [CW-1:0]                      off_cw;
  logic                               hit;

  logic                               seen_r;
  logic                               seen_nxt;
  logic [POS_OUT_W-1:0]               kept_r;
  logic [POS_OUT_W-1:0]               kept_nxt;

  logic                               out_valid_r;
  logic                               out_found_r;
  logic [POS_OUT_W-1:0]               out_pos_r;

  bcfps_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign pat_flat = cfg.pattern;

  always_comb begin
    if (cfg.length == '0) begin
      len_used = LEN_W'(1);
    end else if (cfg.length > LEN_W'(MAX_PATTERN)) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = cfg.length;
    end
  end

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmp_en      = (pos_r < POS_W'(MAX_BUFFER));
  assign shift_en    = in_fire && cmp_en;
  assign text_folded = fold_byte(in_ch.text_byte, cfg.fold);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [PIDX_W-1:0] pidx;
    logic [BYTE_W-1:0] chain_in;

    assign pidx         = PIDX_W'(len_used - LEN_W'(1) - LEN_W'(k));
    assign used_mask[k] = (LEN_W'(k) < len_used);

    if (k == 0) begin : g_head
      assign chain_in = text_folded;
    end else begin : g_body
      assign chain_in = win[k-1];
    end

    bcfps_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .fold_en  (cfg.fold),
      .byte_in  (chain_in),
      .pat_byte (pat_flat[pidx*BYTE_W +: BYTE_W]),
      .byte_out (win[k]),
      .eq       (eq[k])
    );
  end

  assign all_eq    = &(eq | ~used_mask);
  assign end_pos   = CW'(s1_pos_r) + CW'(1);
  assign len_cw    = CW'(len_used);
  assign start_pos = end_pos - len_cw;
  assign off_cw    = CW'(s1_off_r);
  assign hit       = s1_cmp_r && (end_pos >= len_cw) && all_eq;

  always_comb begin
    seen_nxt = seen_r;
    kept_nxt = kept_r;
    if (hit) begin
      if (!cfg.backward) begin
        if (!seen_r && (start_pos >= off_cw)) begin
          seen_nxt = 1'b1;
          kept_nxt = end_pos[POS_OUT_W-1:0];
        end
      end else if (CW'(s1_pos_r) < off_cw) begin
        seen_nxt = 1'b1;
        kept_nxt = start_pos[POS_OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      seen_r      <= 1'b0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_ch.last_byte) begin
          pos_r <= '0;
        end else if (cmp_en) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        if (s1_last_r) begin
          seen_r <= 1'b0;
          kept_r <= '0;
        end else begin
          seen_r <= seen_nxt;
          kept_r <= kept_nxt;
        end
      end

      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmp_r  <= cmp_en;
      s1_last_r <= in_ch.last_byte;
      s1_pos_r  <= pos_r;
      s1_off_r  <= in_ch.search_offset;
    end
    if (s1_fire && s1_last_r) begin
      out_found_r <= seen_nxt;
      out_pos_r   <= seen_nxt ? kept_nxt : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.match_position = out_pos_r;

  `BCFPS_ASSERT_NEXT(a_result_after_last, s1_fire && s1_last_r, out_valid_r, "no result after last byte")
  `BCFPS_ASSERT_NEXT(a_clear_after_result, s1_fire && s1_last_r, !seen_r && (kept_r == '0), "match state not cleared")
  `BCFPS_ASSERT_SAME(a_not_found_zero, out_valid_r && !out_found_r, out_pos_r == '0, "position set without match")
  `BCFPS_ASSERT_SAME(a_pos_bound, 1'b1, pos_r <= POS_W'(MAX_BUFFER), "byte position past buffer limit")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Pattern search unit testbench
// Streams text buffers into the search unit over the valid/ready input channel
// and checks every result transaction against a cycle-free predictor of the
// window compare. Directed buffers cover reset defaults, both search
// directions, case folding, out-of-range lengths and an unused register index.
// Random configuration phases then follow, with random idling on both sides
// and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bcfps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [POS_OUT_W-1:0] OFFSET_MAX = 17'd65536;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] position;
  } search_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bcfps_in_if  in_ch ();
  bcfps_out_if out_ch ();

  bidirectional_case_fold_pattern_search_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] model_pattern;
  logic [LEN_W-1:0]     model_length;
  logic                 model_backward;
  logic                 model_fold;
  logic [BYTE_W-1:0]    model_window [PATTERN_BYTES];
  int unsigned          model_count;
  logic                 model_seen;
  logic [POS_OUT_W-1:0] model_kept;

  search_result_t    expected_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on;
  bit                pressure_req;
  bit                pressure_done = 1'b0;
  int unsigned       rx_gap = 0;
  logic [BYTE_W-1:0] phase_pattern [PATTERN_BYTES];

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      rx_gap = LONG_HOLD;
    end else if (rx_gap == 0 && idle_on && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 17);
    end
    if (rx_gap > 0) begin
      out_ch.ready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found %0b position %0d",
                 $time, out_ch.found, out_ch.match_position);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b actual %0b",
                   $time, want.found, out_ch.found);
          mismatch_count++;
        end
        if (out_ch.match_position !== want.position) begin
          $display("%0t: match_position mismatch, expected %0d actual %0d",
                   $time, want.position, out_ch.match_position);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c);
    if (model_fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned i);
    return model_pattern[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned active_length();
    int unsigned n;
    n = model_length;
    if (n == 0) begin
      n = 1;
    end
    if (n > PATTERN_BYTES) begin
      n = PATTERN_BYTES;
    end
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] random_char();
    string letters;
    logic [BYTE_W-1:0] edges [6];
    int unsigned r;
    letters = "abAB";
    edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h5A, 8'h7A};
    r = $urandom_range(0, 15);
    if (r < 10) begin
      return letters[$urandom_range(0, 3)];
    end else if (r < 13) begin
      return edges[$urandom_range(0, 5)];
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic clear_search_state();
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      model_window[k] = '0;
    end
    model_count = 0;
    model_seen = 1'b0;
    model_kept = '0;
  endtask

  task automatic predict_search_byte(input logic [BYTE_W-1:0] b,
                                     input logic [POS_OUT_W-1:0] offset,
                                     input logic last);
    int unsigned n;
    int unsigned start;
    logic hit;
    search_result_t res;
    if (model_count < MAX_BUFFER_DEF) begin
      n = active_length();
      for (int k = PATTERN_BYTES - 1; k > 0; k--) begin
        model_window[k] = model_window[k - 1];
      end
      model_window[0] = b;
      hit = (model_count + 1 >= n);
      for (int k = 0; k < n; k++) begin
        if (fold_char(model_window[k]) != fold_char(pattern_at(n - 1 - k))) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        start = model_count + 1 - n;
        if (!model_backward) begin
          if (!model_seen && start >= offset) begin
            model_seen = 1'b1;
            model_kept = POS_OUT_W'(model_count + 1);
          end
        end else if (model_count < offset) begin
          model_seen = 1'b1;
          model_kept = POS_OUT_W'(start);
        end
      end
      model_count++;
    end
    if (last) begin
      res.found = model_seen;
      res.position = model_seen ? model_kept : '0;
      expected_results.push_back(res);
      clear_search_state();
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [POS_OUT_W-1:0] offset,
                           input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.search_offset <= offset;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_search_byte(b, offset, last);
  endtask

  task automatic send_text(input string s, input logic [POS_OUT_W-1:0] offset);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], offset, i == s.len() - 1);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
        model_pattern[idx[1:0]] = value;
      end
      REG_LENGTH: begin
        model_length = value[LEN_W-1:0];
      end
      REG_BACKWARD: begin
        model_backward = value[0];
      end
      REG_CASE_FOLD: begin
        model_fold = value[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic load_pattern(input string s);
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      phase_pattern[i] = (i < s.len()) ? s[i] : 8'h00;
    end
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic back, input logic fold);
    logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] words;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      words[i / 8][(i % 8) * 8 +: 8] = phase_pattern[i];
    end
    wait_idle();
    write_reg(REG_PATTERN_0, words[0]);
    write_reg(REG_PATTERN_1, words[1]);
    write_reg(REG_PATTERN_2, words[2]);
    write_reg(REG_PATTERN_3, words[3]);
    write_reg(REG_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_BACKWARD, CFG_DATA_W'(back));
    write_reg(REG_CASE_FOLD, CFG_DATA_W'(fold));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // zero pattern byte of length one, then a window too short for length four
    send_byte(8'hFF, '0, 1'b0);
    send_byte(8'h00, '0, 1'b1);
    load_pattern("");
    configure(6'd4, 1'b0, 1'b0);
    send_byte(8'h00, '0, 1'b0);
    send_byte(8'h00, '0, 1'b0);
    send_byte(8'h00, '0, 1'b1);
  endtask

  task automatic test_forward_search();
    load_pattern("ab");
    configure(6'd2, 1'b0, 1'b0);
    send_text("abab", 17'd1);
    send_text("abab", OFFSET_MAX);
  endtask

  task automatic test_backward_search();
    load_pattern("ab");
    configure(6'd2, 1'b1, 1'b0);
    send_text("abab", 17'd3);
    send_text("abab", OFFSET_MAX);
  endtask

  task automatic test_case_fold();
    load_pattern("A@z");
    configure(6'd3, 1'b0, 1'b1);
    send_text("a@Z", '0);
    configure(6'd3, 1'b0, 1'b0);
    send_text("a@Z", '0);
  endtask

  task automatic test_length_limits();
    load_pattern("q");
    configure(6'd0, 1'b0, 1'b0);
    send_text("zq", '0);
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      phase_pattern[i] = 8'hFF;
    end
    configure(6'd63, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_UNUSED, '1);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      send_byte(8'hFF, '0, i == PATTERN_BYTES - 1);
    end
  endtask

  task automatic test_random_buffers(input int unsigned target);
    int unsigned sent;
    int unsigned r;
    int unsigned len_sel;
    int unsigned eff;
    int unsigned blen;
    int unsigned where;
    logic [POS_OUT_W-1:0] offset;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] buf_bytes [48];
    sent = 0;
    while (sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        phase_pattern[i] = random_char();
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len_sel = $urandom_range(1, 4);
      end else if (r == 7) begin
        len_sel = $urandom_range(5, 32);
      end else if (r == 8) begin
        len_sel = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(32, 63);
      end else begin
        len_sel = 1;
      end
      configure(LEN_W'(len_sel), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      eff = active_length();
      repeat (6) begin
        blen = $urandom_range(1, (eff > 4) ? eff + 12 : 16);
        for (int i = 0; i < blen; i++) begin
          buf_bytes[i] = random_char();
        end
        if ($urandom_range(0, 1) != 0 && blen >= eff) begin
          where = $urandom_range(0, blen - eff);
          for (int i = 0; i < eff; i++) begin
            c = phase_pattern[i];
            if ((c | CASE_DELTA) >= 8'h61 && (c | CASE_DELTA) <= 8'h7A
                && $urandom_range(0, 1) != 0) begin
              c = c ^ CASE_DELTA;
            end
            buf_bytes[where + i] = c;
          end
        end
        r = $urandom_range(0, 15);
        if (r == 0) begin
          offset = OFFSET_MAX;
        end else if (r < 3) begin
          offset = POS_OUT_W'($urandom_range(0, OFFSET_MAX));
        end else begin
          offset = POS_OUT_W'($urandom_range(0, blen + 1));
        end
        for (int i = 0; i < blen; i++) begin
          send_byte(buf_bytes[i], offset, i == blen - 1);
        end
        sent += blen;
      end
    end
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    load_pattern("a");
    configure(6'd1, 1'b0, 1'b0);
    pressure_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_byte(random_char(), POS_OUT_W'($urandom_range(0, 1)), 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    load_pattern("aB");
    configure(6'd2, 1'b1, 1'b1);
    for (int i = 0; i < 40; i++) begin
      send_byte(random_char(), 17'd12, (i % 10) == 9);
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.search_offset = '0;
    in_ch.last_byte = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    pressure_req = 1'b0;
    model_pattern = '0;
    model_length = 6'd1;
    model_backward = 1'b0;
    model_fold = 1'b0;
    clear_search_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_forward_search();
    test_backward_search();
    test_case_fold();
    test_length_limits();
    test_random_buffers(250);
    test_output_backpressure();
    test_steady_stream();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bcfps_pkg.sv
rtl/core/bcfps_ifs.sv
rtl/core/bcfps_regs.sv
rtl/core/bcfps_cell.sv
rtl/core/bidirectional_case_fold_pattern_search_unit.sv
bench/testbench.sv
